// ----- rtl/sntf_pkg.sv -----
`timescale 1ns / 1ps

package sntf_pkg;

    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 32;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_PHASE_STEP  = 2'd0,
        REG_TONE_LENGTH = 2'd1,
        REG_FADE_LENGTH = 2'd2
    } cfg_reg_t;

    // entries of the state memory
    typedef enum logic {
        ADDR_INDEX = 1'b0,
        ADDR_PHASE = 1'b1
    } mem_addr_t;

    // sine polynomial: signed Q2.30 in a 33 bit word
    localparam int FRAC_BITS = 30;
    localparam int MUL_BITS  = 33;

    typedef logic signed [MUL_BITS-1:0] mul_t;

    localparam mul_t C1 = 33'sd1686629713;
    localparam mul_t C3 = -33'sd693598668;
    localparam mul_t C5 = 33'sd85569306;
    localparam mul_t C7 = -33'sd5026995;
    localparam mul_t C9 = 33'sd172271;

endpackage

// ----- rtl/sntf_if.sv -----
`timescale 1ns / 1ps

interface sntf_ctrl_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink (input valid, input restart, output ready);
endinterface

interface sntf_audio_if #(parameter int SAMPLE_BITS = 16);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last;
    logic                          done_res;

    modport source (output valid, output sample, output last, output done_res, input ready);
    modport sink (input valid, input sample, input last, input done_res, output ready);
endinterface

interface sntf_cfg_if import sntf_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/sine_tone_with_linear_fade.sv -----
// channel  dir  payload                          accepted when
// ctrl     in   restart                          ctrl.valid && ctrl.ready
// audio    out  sample, last, done_res           audio.valid && audio.ready
// cfg      in   index, data (0 step, 1 len, 2 fade)  cfg.valid && cfg.ready
//
// a sample of a running tone reaches the output register after its request is taken via
// a bit-serial phase multiply, six shared-multiplier passes of the sine polynomial, then
// the bit-serial gain divider; with fade 0 the divider is skipped
// a request after the tone has ended is answered straight from the state read, with
// done_res set, a zero sample and no phase, sine or divider step
// index and phase sit in a two-entry state memory, cleared by reset through valid bits
// ctrl is taken only when the sequencer is idle, at the earliest once the previous result
// has moved to the output register; cfg is always ready
`timescale 1ns / 1ps

module sine_tone_with_linear_fade import sntf_pkg::*; #(
    parameter int PHASE_BITS  = 32,
    parameter int TABLE_BITS  = 10,
    parameter int SAMPLE_BITS = 16,
    parameter int COUNT_BITS  = 24
) (
    input  logic          clk,
    input  logic          rst_n,
    sntf_ctrl_if.sink     ctrl,
    sntf_audio_if.source  audio,
    sntf_cfg_if.sink      cfg
);

    localparam int IDX_BITS  = COUNT_BITS + 1;
    localparam int WORD_BITS = (PHASE_BITS > IDX_BITS) ? PHASE_BITS : IDX_BITS;
    localparam int STEP_W    = (PHASE_BITS > CFG_DATA_BITS) ? PHASE_BITS : CFG_DATA_BITS;
    localparam int BIT_W     = $clog2(COUNT_BITS);
    localparam int MB        = SAMPLE_BITS - 1;

    typedef enum logic [2:0] {
        ST_IDLE, ST_RD, ST_PHASE, ST_WR_PH, ST_WR_IX, ST_SINE, ST_DIV_GO, ST_DIV
    } ctl_state_t;

    ctl_state_t                    state_reg;
    logic                          restart_reg;
    logic [IDX_BITS-1:0]           idx_reg;
    logic [COUNT_BITS-1:0]         num_reg;
    logic                          bypass_reg;
    logic                          last_pend_reg;
    logic                          done_pend_reg;
    logic signed [SAMPLE_BITS-1:0] sample_pend_reg;
    logic                          emit_reg;
    logic [PHASE_BITS-1:0]         acc_reg;
    logic [BIT_W-1:0]              bit_cnt_reg;
    logic                          out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] out_sample_reg;
    logic                          out_last_reg;
    logic                          out_done_reg;

    logic [CFG_DATA_BITS-1:0] phase_step;
    logic [COUNT_BITS-1:0]    tone_length;
    logic [COUNT_BITS-1:0]    fade_length;

    logic                     mem_we;
    mem_addr_t                mem_waddr;
    logic [WORD_BITS-1:0]     mem_wdata;
    logic [WORD_BITS-1:0]     mem_rdata;

    logic                     sine_done;
    logic [MB-1:0]            sine_mag;
    logic                     sine_neg;
    logic                     div_done;
    logic [MB-1:0]            div_quot;

    logic [IDX_BITS-1:0]      idx_rd;
    logic [IDX_BITS-1:0]      tone_x;
    logic [IDX_BITS:0]        fade_sum;
    logic                     finished;
    logic [COUNT_BITS-1:0]    num_next;
    logic                     last_next;
    logic [STEP_W-1:0]        step_w;
    logic [PHASE_BITS-1:0]    step_p;
    logic [COUNT_BITS-1:0]    idx_low;
    logic [PHASE_BITS-1:0]    acc_next;
    logic [MB-1:0]            mag_sel;
    logic signed [SAMPLE_BITS-1:0] mag_ext;
    logic signed [SAMPLE_BITS-1:0] sample_next;

    sntf_cfg_regs #(.COUNT_BITS(COUNT_BITS)) u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .phase_step  (phase_step),
        .tone_length (tone_length),
        .fade_length (fade_length)
    );

    sntf_state_mem #(.WORD_BITS(WORD_BITS)) u_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (ADDR_INDEX),
        .rdata (mem_rdata)
    );

    sntf_sine #(.TABLE_BITS(TABLE_BITS), .SAMPLE_BITS(SAMPLE_BITS)) u_sine (
        .clk   (clk),
        .rst_n (rst_n),
        .start (state_reg == ST_WR_PH),
        .idx   (acc_reg[PHASE_BITS-1 -: TABLE_BITS]),
        .done  (sine_done),
        .mag   (sine_mag),
        .neg   (sine_neg)
    );

    sntf_gain_div #(.SAMPLE_BITS(SAMPLE_BITS), .COUNT_BITS(COUNT_BITS)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (state_reg == ST_DIV_GO),
        .mag   (sine_mag),
        .num   (num_reg),
        .den   (fade_length),
        .done  (div_done),
        .quot  (div_quot)
    );

    // index of this sample and its envelope numerator
    always_comb
    begin
        idx_rd    = restart_reg ? '0 : mem_rdata[IDX_BITS-1:0];
        tone_x    = IDX_BITS'(tone_length);
        finished  = idx_rd >= tone_x;
        fade_sum  = (IDX_BITS+1)'(idx_rd) + (IDX_BITS+1)'(fade_length);
        if (fade_sum >= (IDX_BITS+1)'(tone_length))
            num_next = tone_length - idx_rd[COUNT_BITS-1:0];
        else if (idx_rd < IDX_BITS'(fade_length))
            num_next = idx_rd[COUNT_BITS-1:0];
        else
            num_next = fade_length;
        last_next = IDX_BITS'(idx_rd + 1'b1) == tone_x;
    end

    // phase = index * step, one index bit a cycle from the top
    always_comb
    begin
        step_w   = STEP_W'(phase_step);
        step_p   = step_w[PHASE_BITS-1:0];
        idx_low  = idx_reg[COUNT_BITS-1:0];
        acc_next = {acc_reg[PHASE_BITS-2:0], 1'b0} + (idx_low[bit_cnt_reg] ? step_p : '0);
    end

    always_comb
    begin
        mag_sel     = (state_reg == ST_DIV) ? div_quot : sine_mag;
        mag_ext     = $signed({1'b0, mag_sel});
        sample_next = sine_neg ? -mag_ext : mag_ext;
    end

    // a restart on a finished tone still clears the stored index
    always_comb
    begin
        mem_we    = (state_reg == ST_WR_PH) || (state_reg == ST_WR_IX) ||
                    ((state_reg == ST_RD) && finished && restart_reg);
        mem_waddr = (state_reg == ST_WR_PH) ? ADDR_PHASE : ADDR_INDEX;
        if (state_reg == ST_WR_PH)
            mem_wdata = WORD_BITS'(acc_reg);
        else if (state_reg == ST_WR_IX)
            mem_wdata = WORD_BITS'(IDX_BITS'(idx_reg + 1'b1));
        else
            mem_wdata = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            emit_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // a finished sample waits here until the output register is free
            if (emit_reg && (!out_valid_reg || audio.ready))
            begin
                out_valid_reg  <= 1'b1;
                out_sample_reg <= sample_pend_reg;
                out_last_reg   <= last_pend_reg;
                out_done_reg   <= done_pend_reg;
                emit_reg       <= 1'b0;
            end
            else if (audio.ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (ctrl.valid && !emit_reg)
                    begin
                        restart_reg <= ctrl.restart;
                        state_reg   <= ST_RD;
                    end
                end
                ST_RD:
                begin
                    if (finished)
                    begin
                        sample_pend_reg <= '0;
                        last_pend_reg   <= 1'b0;
                        done_pend_reg   <= 1'b1;
                        emit_reg        <= 1'b1;
                        state_reg       <= ST_IDLE;
                    end
                    else
                    begin
                        idx_reg       <= idx_rd;
                        num_reg       <= num_next;
                        bypass_reg    <= fade_length == '0;
                        last_pend_reg <= last_next;
                        done_pend_reg <= 1'b0;
                        acc_reg       <= '0;
                        bit_cnt_reg   <= BIT_W'(COUNT_BITS - 1);
                        state_reg     <= ST_PHASE;
                    end
                end
                ST_PHASE:
                begin
                    acc_reg <= acc_next;
                    if (bit_cnt_reg == '0)
                        state_reg <= ST_WR_PH;
                    else
                        bit_cnt_reg <= bit_cnt_reg - 1'b1;
                end
                ST_WR_PH: state_reg <= ST_WR_IX;
                ST_WR_IX: state_reg <= ST_SINE;
                ST_SINE:
                begin
                    if (sine_done)
                    begin
                        if (bypass_reg)
                        begin
                            sample_pend_reg <= sample_next;
                            emit_reg        <= 1'b1;
                            state_reg       <= ST_IDLE;
                        end
                        else
                            state_reg <= ST_DIV_GO;
                    end
                end
                ST_DIV_GO: state_reg <= ST_DIV;
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        sample_pend_reg <= sample_next;
                        emit_reg        <= 1'b1;
                        state_reg       <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign ctrl.ready     = (state_reg == ST_IDLE) && !emit_reg;
    assign audio.valid    = out_valid_reg;
    assign audio.sample   = out_sample_reg;
    assign audio.last     = out_last_reg;
    assign audio.done_res = out_done_reg;

    a_done_is_silent: assert property (@(posedge clk) disable iff (!rst_n)
        audio.valid && audio.done_res |-> audio.sample == '0 && !audio.last)
        else $error("finished-tone result carries a sample or last");

    a_request_reads: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.valid && ctrl.ready |=> state_reg == ST_RD)
        else $error("accepted request did not start a state read");

    a_sine_when_waited: assert property (@(posedge clk) disable iff (!rst_n)
        sine_done |-> state_reg == ST_SINE)
        else $error("sine result arrived while not waited for");

    a_gain_bound: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> div_quot <= sine_mag)
        else $error("faded magnitude exceeds full-scale magnitude");

endmodule

// ----- rtl/sntf_cfg_regs.sv -----
`timescale 1ns / 1ps

module sntf_cfg_regs import sntf_pkg::*; #(
    parameter int COUNT_BITS = 24
) (
    input  logic                     clk,
    input  logic                     rst_n,
    sntf_cfg_if.sink                 cfg,
    output logic [CFG_DATA_BITS-1:0] phase_step,
    output logic [COUNT_BITS-1:0]    tone_length,
    output logic [COUNT_BITS-1:0]    fade_length
);

    logic [CFG_DATA_BITS-1:0] phase_step_reg;
    logic [COUNT_BITS-1:0]    tone_length_reg;
    logic [COUNT_BITS-1:0]    fade_length_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg  <= '0;
            tone_length_reg <= '0;
            fade_length_reg <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_PHASE_STEP:  phase_step_reg  <= cfg.data;
                REG_TONE_LENGTH: tone_length_reg <= cfg.data[COUNT_BITS-1:0];
                REG_FADE_LENGTH: fade_length_reg <= cfg.data[COUNT_BITS-1:0];
                default:         ;
            endcase
        end
    end

    assign phase_step  = phase_step_reg;
    assign tone_length = tone_length_reg;
    assign fade_length = fade_length_reg;

endmodule

// ----- rtl/sntf_state_mem.sv -----
`timescale 1ns / 1ps

module sntf_state_mem import sntf_pkg::*; #(
    parameter int WORD_BITS = 33
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 we,
    input  mem_addr_t            waddr,
    input  logic [WORD_BITS-1:0] wdata,
    input  mem_addr_t            raddr,
    output logic [WORD_BITS-1:0] rdata
);

    logic [WORD_BITS-1:0] mem [2];
    logic [1:0]           vld_reg;
    logic [WORD_BITS-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    // entries never written since reset read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (we)
            vld_reg[waddr] <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= vld_reg[raddr] ? mem[raddr] : '0;
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/sntf_sine.sv -----
`timescale 1ns / 1ps

module sntf_sine import sntf_pkg::*; #(
    parameter int TABLE_BITS  = 10,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [TABLE_BITS-1:0]  idx,
    output logic                   done,
    output logic [SAMPLE_BITS-2:0] mag,
    output logic                   neg
);

    localparam int QTR = TABLE_BITS - 2;
    localparam int MB  = SAMPLE_BITS - 1;
    localparam int SH  = FRAC_BITS - MB;
    localparam logic [MUL_BITS-1:0] AMP_MAX = MUL_BITS'((1 << MB) - 1);
    localparam logic [MUL_BITS-1:0] RND_ONE = MUL_BITS'(1 << (SH - 1));
    localparam logic [2:0] STEP_X2 = 3'd0;
    localparam logic [2:0] STEP_V  = 3'd5;

    typedef enum logic [1:0] {S_IDLE, S_MUL, S_ACC, S_OUT} sine_state_t;

    sine_state_t st_reg;
    logic [2:0]  step_reg;
    logic        done_reg;
    logic        neg_reg;
    logic [MB-1:0] mag_reg;
    mul_t        xq_reg;
    mul_t        x2_reg;
    mul_t        p_reg;
    logic signed [2*MUL_BITS-1:0] prod_reg;

    logic [QTR-1:0]      r;
    logic [QTR:0]        x;
    logic [MUL_BITS-1:0] xq_u;
    mul_t                mul_a;
    mul_t                mul_b;
    mul_t                coef;
    logic signed [2*MUL_BITS-1:0] prod_shr;
    mul_t                prod_trunc;
    logic [MUL_BITS-1:0] rnd_u;
    logic [MUL_BITS-1:0] m_u;
    logic [MB-1:0]       mag_next;

    // fold the table index into a quarter wave, x in Q1.30
    always_comb
    begin
        r    = idx[QTR-1:0];
        x    = idx[QTR] ? (((QTR+1)'(1) << QTR) - {1'b0, r}) : {1'b0, r};
        xq_u = MUL_BITS'({x, {(FRAC_BITS-QTR){1'b0}}});
    end

    always_comb
    begin
        mul_a = (step_reg == STEP_X2) ? xq_reg : p_reg;
        mul_b = (step_reg == STEP_X2 || step_reg == STEP_V) ? xq_reg : x2_reg;
        case (step_reg)
            3'd1:    coef = C7;
            3'd2:    coef = C5;
            3'd3:    coef = C3;
            default: coef = C1;
        endcase
        // arithmetic shift floors, as the products need
        prod_shr   = prod_reg >>> FRAC_BITS;
        prod_trunc = $signed(prod_shr[MUL_BITS-1:0]);
    end

    always_comb
    begin
        rnd_u = $unsigned(p_reg) + RND_ONE;
        m_u   = rnd_u >> SH;
        if (p_reg[MUL_BITS-1])
            mag_next = '0;
        else if (m_u > AMP_MAX)
            mag_next = AMP_MAX[MB-1:0];
        else
            mag_next = m_u[MB-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= S_IDLE;
            step_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (st_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        xq_reg   <= $signed(xq_u);
                        p_reg    <= C9;
                        neg_reg  <= idx[TABLE_BITS-1];
                        step_reg <= STEP_X2;
                        st_reg   <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    prod_reg <= mul_a * mul_b;
                    st_reg   <= S_ACC;
                end
                S_ACC:
                begin
                    case (step_reg)
                        STEP_X2: x2_reg <= prod_trunc;
                        STEP_V:  p_reg  <= prod_trunc;
                        default: p_reg  <= coef + prod_trunc;
                    endcase
                    if (step_reg == STEP_V)
                        st_reg <= S_OUT;
                    else
                    begin
                        step_reg <= step_reg + 3'd1;
                        st_reg   <= S_MUL;
                    end
                end
                S_OUT:
                begin
                    mag_reg  <= mag_next;
                    done_reg <= 1'b1;
                    st_reg   <= S_IDLE;
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end

    assign done = done_reg;
    assign mag  = mag_reg;
    assign neg  = neg_reg;

endmodule

// ----- rtl/sntf_gain_div.sv -----
`timescale 1ns / 1ps

module sntf_gain_div #(
    parameter int SAMPLE_BITS = 16,
    parameter int COUNT_BITS  = 24
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [SAMPLE_BITS-2:0] mag,
    input  logic [COUNT_BITS-1:0]  num,
    input  logic [COUNT_BITS-1:0]  den,
    output logic                   done,
    output logic [SAMPLE_BITS-2:0] quot
);

    localparam int MB    = SAMPLE_BITS - 1;
    localparam int DB    = MB + COUNT_BITS;
    localparam int CNT_W = $clog2(MB);

    typedef enum logic [1:0] {D_IDLE, D_LOAD, D_DIV} div_state_t;

    div_state_t         st_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               done_reg;
    logic [DB-1:0]      dvd_reg;
    logic [COUNT_BITS-1:0] rem_reg;
    logic [MB-1:0]      low_reg;

    logic [COUNT_BITS:0] trial;
    logic [COUNT_BITS:0] diff;
    logic                ge;

    // num <= den, so the quotient fits in MB bits and the top part starts below den
    always_comb
    begin
        trial = {rem_reg, low_reg[MB-1]};
        diff  = trial - {1'b0, den};
        ge    = trial >= {1'b0, den};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= D_IDLE;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (st_reg)
                D_IDLE:
                begin
                    if (start)
                    begin
                        dvd_reg <= DB'(mag) * DB'(num);
                        st_reg  <= D_LOAD;
                    end
                end
                D_LOAD:
                begin
                    rem_reg <= dvd_reg[DB-1:MB];
                    low_reg <= dvd_reg[MB-1:0];
                    cnt_reg <= '0;
                    st_reg  <= D_DIV;
                end
                D_DIV:
                begin
                    rem_reg <= ge ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
                    low_reg <= {low_reg[MB-2:0], ge};
                    if (cnt_reg == CNT_W'(MB - 1))
                    begin
                        done_reg <= 1'b1;
                        st_reg   <= D_IDLE;
                    end
                    else
                        cnt_reg <= cnt_reg + 1'b1;
                end
                default: st_reg <= D_IDLE;
            endcase
        end
    end

    assign done = done_reg;
    assign quot = low_reg;

endmodule

// ----- tb/sine_tone_with_linear_fade_tb.sv -----
`timescale 1ns / 1ps

module sine_tone_with_linear_fade_tb import sntf_pkg::*;;

    localparam int unsigned CYCLE_LIMIT  = 1000000;
    localparam int unsigned RANDOM_ITEMS = 1200;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               last;
        logic               done_res;
    } tone_sample_t;

    logic clk = 1'b0;
    logic rst_n;

    sntf_ctrl_if                     ctrl_bus ();
    sntf_audio_if #(.SAMPLE_BITS(16)) audio_bus ();
    sntf_cfg_if                      cfg_bus ();

    sine_tone_with_linear_fade i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl_bus),
        .audio (audio_bus),
        .cfg   (cfg_bus)
    );

    // predicted block state and registers
    logic [31:0] phase_step_cfg = '0;
    logic [23:0] tone_len_cfg   = '0;
    logic [23:0] fade_len_cfg   = '0;
    logic [31:0] tone_phase     = '0;
    logic [24:0] tone_index     = '0;

    bit           restart_queue[$];
    tone_sample_t tone_expect_q[$];

    int unsigned ctrl_issued     = 0;
    int unsigned ctrl_taken      = 0;
    int unsigned tone_results    = 0;
    int unsigned mismatches      = 0;
    int unsigned cycle_count     = 0;
    int unsigned requests_queued = 0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // quarter-wave fold plus odd polynomial, result in q1.15
    function automatic longint sine_q15(logic [31:0] phase);
        logic [9:0] tidx;
        longint     x;
        longint     xq;
        longint     x2;
        longint     p;
        longint     v;
        longint     m;
        begin
            tidx = phase[31:22];
            if (tidx[8])
                x = longint'(256) - longint'(tidx[7:0]);
            else
                x = longint'(tidx[7:0]);
            xq = x <<< 22;
            x2 = (xq * xq) >>> FRAC_BITS;
            p  = C9;
            p  = C7 + ((p * x2) >>> FRAC_BITS);
            p  = C5 + ((p * x2) >>> FRAC_BITS);
            p  = C3 + ((p * x2) >>> FRAC_BITS);
            p  = C1 + ((p * x2) >>> FRAC_BITS);
            v  = (p * xq) >>> FRAC_BITS;
            if (v < 0)
                v = 0;
            m = (v + (longint'(1) <<< 14)) >>> 15;
            if (m > 32767)
                m = 32767;
            sine_q15 = tidx[9] ? -m : m;
        end
    endfunction

    function automatic tone_sample_t next_tone_sample(logic restart);
        tone_sample_t      res;
        longint unsigned   pos;
        longint unsigned   prod;
        longint unsigned   num;
        longint unsigned   mag;
        longint            amp;
        bit                neg;
        begin
            res = '0;
            if (restart)
            begin
                tone_index = '0;
                tone_phase = '0;
            end
            if (tone_index >= {1'b0, tone_len_cfg})
            begin
                res.done_res = 1'b1;
            end
            else
            begin
                pos        = 64'(tone_index);
                prod       = pos * longint'(phase_step_cfg);
                tone_phase = prod[31:0];
                amp        = sine_q15(tone_phase);
                num        = 64'(fade_len_cfg);
                if (fade_len_cfg != 0)
                begin
                    // fade-out takes precedence over fade-in
                    if (pos + fade_len_cfg >= tone_len_cfg)
                        num = tone_len_cfg - pos;
                    else if (pos < fade_len_cfg)
                        num = pos;
                end
                neg = amp < 0;
                mag = neg ? -amp : amp;
                if (fade_len_cfg != 0)
                    mag = mag * num / fade_len_cfg;
                amp          = neg ? -longint'(mag) : longint'(mag);
                res.sample   = amp[15:0];
                res.last     = (pos + 1 == tone_len_cfg);
                tone_index   = 25'(pos + 1);
            end
            next_tone_sample = res;
        end
    endfunction

    // random backpressure, with a quiet window
    function automatic bit stall_now(int unsigned count);
        stall_now = (count < 400 || count >= 700) && ($urandom_range(99) < 17);
    endfunction

    // request driver
    always @(negedge clk)
    begin
        if (rst_n && ctrl_taken == ctrl_issued)
        begin
            if (restart_queue.size() != 0 && !stall_now(ctrl_issued))
            begin
                ctrl_bus.valid   <= 1'b1;
                ctrl_bus.restart <= restart_queue.pop_front();
                ctrl_issued      <= ctrl_issued + 1;
            end
            else
            begin
                ctrl_bus.valid   <= 1'b0;
                ctrl_bus.restart <= 1'($urandom_range(1));
            end
        end
        audio_bus.ready <= !stall_now(tone_results);
    end

    // monitor: register writes, accepted requests and returned samples
    always @(posedge clk)
    begin
        tone_sample_t want;
        if (rst_n)
        begin
            if (cfg_bus.valid && cfg_bus.ready)
            begin
                case (cfg_bus.index)
                    REG_PHASE_STEP:  phase_step_cfg = cfg_bus.data;
                    REG_TONE_LENGTH: tone_len_cfg   = cfg_bus.data[23:0];
                    REG_FADE_LENGTH: fade_len_cfg   = cfg_bus.data[23:0];
                    default: ;
                endcase
            end
            if (ctrl_bus.valid && ctrl_bus.ready)
            begin
                tone_expect_q.push_back(next_tone_sample(ctrl_bus.restart));
                ctrl_taken = ctrl_taken + 1;
            end
            if (audio_bus.valid && audio_bus.ready)
            begin
                tone_results = tone_results + 1;
                if (tone_expect_q.size() == 0)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("unexpected sample %0d last %0b done %0b",
                                 audio_bus.sample, audio_bus.last, audio_bus.done_res);
                end
                else
                begin
                    want = tone_expect_q.pop_front();
                    if (audio_bus.sample !== want.sample || audio_bus.last !== want.last ||
                        audio_bus.done_res !== want.done_res)
                    begin
                        mismatches = mismatches + 1;
                        if (mismatches <= 10)
                            $display("sample %0d: expected %0d/%0b/%0b, got %0d/%0b/%0b",
                                     tone_results, want.sample, want.last, want.done_res,
                                     audio_bus.sample, audio_bus.last, audio_bus.done_res);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("sine_tone_with_linear_fade regression: fail");
            $finish;
        end
    end

    task automatic write_reg(cfg_reg_t idx, logic [31:0] value);
        @(negedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        @(posedge clk);
        while (!cfg_bus.ready)
            @(posedge clk);
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic queue_requests(int unsigned count, bit first_restart, int unsigned restart_pct);
        for (int unsigned k = 0; k < count; k++)
        begin
            if (k == 0)
                restart_queue.push_back(first_restart);
            else
                restart_queue.push_back($urandom_range(99) < restart_pct);
        end
        requests_queued += count;
    endtask

    // wait until every request has been answered
    task automatic settle();
        while (restart_queue.size() != 0 || ctrl_taken != ctrl_issued ||
               tone_expect_q.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    initial
    begin
        logic [31:0] step;
        logic [23:0] len;
        logic [23:0] fade;

        rst_n            = 1'b0;
        ctrl_bus.valid   = 1'b0;
        ctrl_bus.restart = 1'b0;
        audio_bus.ready  = 1'b0;
        cfg_bus.valid    = 1'b0;
        cfg_bus.index    = REG_PHASE_STEP;
        cfg_bus.data     = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // zero length straight out of reset: every request is past the end
        queue_requests(1, 1'b0, 0);
        queue_requests(1, 1'b1, 0);
        settle();

        // quarter-turn steps hit the fold points, no fade, run past the end
        write_reg(REG_PHASE_STEP, 32'h4000_0000);
        write_reg(REG_TONE_LENGTH, 32'd8);
        write_reg(REG_FADE_LENGTH, 32'd0);
        queue_requests(10, 1'b1, 0);
        settle();

        // fade longer than half the tone
        write_reg(REG_PHASE_STEP, 32'hFFFF_FFFF);
        write_reg(REG_TONE_LENGTH, 32'd6);
        write_reg(REG_FADE_LENGTH, 32'd5);
        queue_requests(7, 1'b1, 0);
        settle();

        // length cut below the current index, then restart
        write_reg(REG_TONE_LENGTH, 32'd3);
        queue_requests(2, 1'b0, 0);
        queue_requests(1, 1'b1, 0);
        settle();

        // longest tone and fade, then a step change mid-tone
        write_reg(REG_PHASE_STEP, 32'h1234_5678);
        write_reg(REG_TONE_LENGTH, 32'h00FF_FFFF);
        write_reg(REG_FADE_LENGTH, 32'h00FF_FFFF);
        queue_requests(3, 1'b1, 0);
        settle();
        write_reg(REG_PHASE_STEP, 32'd0);
        queue_requests(2, 1'b0, 0);
        settle();

        requests_queued = 0;
        while (requests_queued < RANDOM_ITEMS)
        begin
            case ($urandom_range(5))
                0:       step = 32'd0;
                1:       step = 32'hFFFF_FFFF;
                default: step = $urandom;
            endcase
            case ($urandom_range(9))
                0:       len = '0;
                1:       len = 24'hFF_FFFF;
                2:       len = 24'($urandom);
                default: len = 24'($urandom_range(60, 1));
            endcase
            case ($urandom_range(7))
                0:       fade = '0;
                1:       fade = 24'hFF_FFFF;
                2:       fade = 24'($urandom);
                default: fade = 24'($urandom_range(len));
            endcase
            if ($urandom_range(99) < 85)
                write_reg(REG_PHASE_STEP, step);
            if ($urandom_range(99) < 85)
                write_reg(REG_TONE_LENGTH, {8'd0, len});
            if ($urandom_range(99) < 85)
                write_reg(REG_FADE_LENGTH, {8'd0, fade});
            queue_requests($urandom_range(80, 5), $urandom_range(99) < 85, 4);
            settle();
        end

        repeat (200) @(posedge clk);
        if (mismatches == 0 && tone_expect_q.size() == 0)
            $display("sine_tone_with_linear_fade regression: pass");
        else
            $display("sine_tone_with_linear_fade regression: fail");
        $finish;
    end

endmodule
